// File: rtl/lptc_pkg.sv
`timescale 1ns / 1ps

package lptc_pkg;

  // Field and datapath widths
  localparam int unsigned IdxW   = 12;
  localparam int unsigned RngW   = 16;
  localparam int unsigned PhaseW = 32;
  localparam int unsigned OffW   = 16;
  localparam int unsigned ScaleW = 24;
  localparam int unsigned PtW    = 24;
  localparam int unsigned XW     = 35;  // rotated vector, mm with 16 fraction bits
  localparam int unsigned ZW     = 34;  // residual angle
  localparam int unsigned BW     = XW + 1;  // after adding the mounting offset
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned MAX_SAMPLES      = 4096;
  localparam int unsigned TRIG_STAGES_DEF  = 16;
  localparam int unsigned TRIG_STAGES_MAX  = 24;

  // 2^32 / cordic gain, applied to the range up front
  localparam logic [31:0] CORDIC_GAIN = 32'h9B74EDA8;

  localparam logic [31:0] ATAN_TAB [TRIG_STAGES_MAX] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [2:0] {
    CFG_RANGE_LOW   = 3'd0,
    CFG_RANGE_HIGH  = 3'd1,
    CFG_ANGLE_START = 3'd2,
    CFG_ANGLE_STEP  = 3'd3,
    CFG_MOUNT_YAW   = 3'd4,
    CFG_OFFSET_X    = 3'd5,
    CFG_OFFSET_Y    = 3'd6,
    CFG_CELL_SCALE  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_e;

  localparam logic [RngW-1:0]   RANGE_LOW_RST  = 16'd120;
  localparam logic [RngW-1:0]   RANGE_HIGH_RST = 16'd8000;
  localparam logic [ScaleW-1:0] CELL_SCALE_RST = 24'd335544;

  typedef struct packed {
    logic [RngW-1:0]          range_low;
    logic [RngW-1:0]          range_high;
    logic [PhaseW-1:0]        angle_start;
    logic [PhaseW-1:0]        angle_step;
    logic [PhaseW-1:0]        mount_yaw;
    logic signed [OffW-1:0]   offset_x;
    logic signed [OffW-1:0]   offset_y;
    logic [ScaleW-1:0]        cell_scale;
  } cfg_t;

  // Control that travels alongside the data through every stage
  typedef struct packed {
    logic valid;
    logic keep;
    logic last;
  } side_t;

endpackage

// File: rtl/lptc_phase.sv
`timescale 1ns / 1ps

module lptc_phase (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic [lptc_pkg::IdxW-1:0]           sample_index_i,
  input  logic [lptc_pkg::RngW-1:0]           range_value_i,
  input  logic                                last_of_scan_i,
  input  lptc_pkg::cfg_t                      cfg_i,
  output lptc_pkg::side_t                     side_o,
  output lptc_pkg::quad_e                     quad_o,
  output logic signed [lptc_pkg::XW-1:0]      x_o,
  output logic signed [lptc_pkg::ZW-1:0]      z_o
);

  localparam int unsigned IdxProdW = lptc_pkg::IdxW + lptc_pkg::PhaseW;
  localparam int unsigned GainProdW = lptc_pkg::RngW + 32;
  localparam int unsigned CmpW = 17;

  // Stage 1: gate, index times step, range times gain
  logic [IdxProdW-1:0]           idx_step_full;
  logic [GainProdW-1:0]          rng_gain_full;
  logic                          keep_d;
  lptc_pkg::side_t               side1_q;
  logic [lptc_pkg::PhaseW-1:0]   idx_step_q;
  logic [31:0]                   x0_q;

  assign idx_step_full = sample_index_i * cfg_i.angle_step;
  assign rng_gain_full = range_value_i * lptc_pkg::CORDIC_GAIN;
  assign keep_d = (range_value_i > cfg_i.range_low) && (range_value_i < cfg_i.range_high)
               && (CmpW'(sample_index_i) < CmpW'(lptc_pkg::MAX_SAMPLES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q <= '0;
    end else begin
      side1_q <= '{valid: in_valid_i, keep: keep_d, last: last_of_scan_i};
    end
  end

  always_ff @(posedge clk_i) begin
    idx_step_q <= idx_step_full[lptc_pkg::PhaseW-1:0];
    x0_q       <= rng_gain_full[GainProdW-1:16];
  end

  // Stage 2: full phase, quadrant fold and residual angle
  logic [lptc_pkg::PhaseW-1:0]   phase;
  logic [lptc_pkg::PhaseW-1:0]   phase_rnd;
  logic [lptc_pkg::PhaseW-1:0]   resid;
  lptc_pkg::side_t               side2_q;
  lptc_pkg::quad_e               quad_q;
  logic signed [lptc_pkg::XW-1:0] x_q;
  logic signed [lptc_pkg::ZW-1:0] z_q;

  assign phase     = cfg_i.angle_start + cfg_i.mount_yaw + idx_step_q;
  assign phase_rnd = phase + 32'h2000_0000;
  assign resid     = phase - {phase_rnd[31:30], 30'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side2_q <= '0;
    end else begin
      side2_q <= side1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    quad_q <= lptc_pkg::quad_e'(phase_rnd[31:30]);
    x_q    <= $signed({{(lptc_pkg::XW-32){1'b0}}, x0_q});
    z_q    <= $signed({{(lptc_pkg::ZW-32){resid[31]}}, resid});
  end

  assign side_o = side2_q;
  assign quad_o = quad_q;
  assign x_o    = x_q;
  assign z_o    = z_q;

endmodule

// File: rtl/lptc_cordic.sv
`timescale 1ns / 1ps

module lptc_cordic #(
  parameter int unsigned TRIG_STAGES = lptc_pkg::TRIG_STAGES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lptc_pkg::side_t                     side_i,
  input  lptc_pkg::quad_e                     quad_i,
  input  logic signed [lptc_pkg::XW-1:0]      x_i,
  input  logic signed [lptc_pkg::ZW-1:0]      z_i,
  output lptc_pkg::side_t                     side_o,
  output lptc_pkg::quad_e                     quad_o,
  output logic signed [lptc_pkg::XW-1:0]      x_o,
  output logic signed [lptc_pkg::XW-1:0]      y_o
);

  lptc_pkg::side_t                side_q [TRIG_STAGES];
  lptc_pkg::quad_e                quad_q [TRIG_STAGES];
  logic signed [lptc_pkg::XW-1:0] x_q    [TRIG_STAGES];
  logic signed [lptc_pkg::XW-1:0] y_q    [TRIG_STAGES];
  logic signed [lptc_pkg::ZW-1:0] z_q    [TRIG_STAGES];

  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
    lptc_pkg::side_t                side_prev;
    lptc_pkg::quad_e                quad_prev;
    logic signed [lptc_pkg::XW-1:0] x_prev;
    logic signed [lptc_pkg::XW-1:0] y_prev;
    logic signed [lptc_pkg::ZW-1:0] z_prev;
    logic signed [lptc_pkg::XW-1:0] dx;
    logic signed [lptc_pkg::XW-1:0] dy;
    logic signed [lptc_pkg::ZW-1:0] da;

    if (i == 0) begin : g_first
      assign side_prev = side_i;
      assign quad_prev = quad_i;
      assign x_prev    = x_i;
      assign y_prev    = '0;
      assign z_prev    = z_i;
    end else begin : g_next
      assign side_prev = side_q[i-1];
      assign quad_prev = quad_q[i-1];
      assign x_prev    = x_q[i-1];
      assign y_prev    = y_q[i-1];
      assign z_prev    = z_q[i-1];
    end

    assign dx = y_prev >>> i;
    assign dy = x_prev >>> i;
    assign da = $signed({{(lptc_pkg::ZW-32){1'b0}}, lptc_pkg::ATAN_TAB[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[i] <= '0;
      end else begin
        side_q[i] <= side_prev;
      end
    end

    // rotate toward zero residual angle
    always_ff @(posedge clk_i) begin
      quad_q[i] <= quad_prev;
      if (!z_prev[lptc_pkg::ZW-1]) begin
        x_q[i] <= x_prev - dx;
        y_q[i] <= y_prev + dy;
        z_q[i] <= z_prev - da;
      end else begin
        x_q[i] <= x_prev + dx;
        y_q[i] <= y_prev - dy;
        z_q[i] <= z_prev + da;
      end
    end
  end

  assign side_o = side_q[TRIG_STAGES-1];
  assign quad_o = quad_q[TRIG_STAGES-1];
  assign x_o    = x_q[TRIG_STAGES-1];
  assign y_o    = y_q[TRIG_STAGES-1];

`ifndef SYNTH
  // compare only once the whole pipe holds post-reset history
  a_valid_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, TRIG_STAGES) |-> side_o.valid == $past(side_i.valid, TRIG_STAGES))
    else $error("cordic valid bit lost or duplicated");

  a_side_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_o.valid |-> (side_o.keep == $past(side_i.keep, TRIG_STAGES)
                      && side_o.last == $past(side_i.last, TRIG_STAGES)))
    else $error("cordic sideband out of step with data");
`endif

endmodule

// File: rtl/lptc_scale.sv
`timescale 1ns / 1ps

module lptc_scale (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lptc_pkg::side_t                     side_i,
  input  lptc_pkg::quad_e                     quad_i,
  input  logic signed [lptc_pkg::XW-1:0]      x_i,
  input  logic signed [lptc_pkg::XW-1:0]      y_i,
  input  lptc_pkg::cfg_t                      cfg_i,
  output logic                                done_o,
  output logic signed [lptc_pkg::PtW-1:0]     point_x_o,
  output logic signed [lptc_pkg::PtW-1:0]     point_y_o,
  output logic                                kept_o,
  output logic                                scan_end_o
);

  localparam int unsigned BW    = lptc_pkg::BW;
  localparam int unsigned LoW   = BW / 2;
  localparam int unsigned HiW   = BW - LoW;
  localparam int unsigned PLoW  = LoW + lptc_pkg::ScaleW;
  localparam int unsigned PHiW  = HiW + lptc_pkg::ScaleW + 1;
  localparam int unsigned FullW = BW + lptc_pkg::ScaleW + 1;
  localparam int unsigned ShW   = FullW - 32;
  localparam int unsigned PtW   = lptc_pkg::PtW;

  function automatic logic signed [PtW-1:0] sat_pt(input logic signed [ShW-1:0] v);
    logic signed [PtW-1:0] r;
    if (v > $signed(ShW'(2**(PtW-1) - 1))) begin
      r = {1'b0, {(PtW-1){1'b1}}};
    end else if (v < -$signed(ShW'(2**(PtW-1)))) begin
      r = {1'b1, {(PtW-1){1'b0}}};
    end else begin
      r = v[PtW-1:0];
    end
    return r;
  endfunction

  // Stage A: quadrant rotation and mounting offset
  logic signed [lptc_pkg::XW-1:0] rx;
  logic signed [lptc_pkg::XW-1:0] ry;
  logic signed [BW-1:0]           offx;
  logic signed [BW-1:0]           offy;
  lptc_pkg::side_t                side_a_q;
  logic signed [BW-1:0]           bx_q;
  logic signed [BW-1:0]           by_q;

  always_comb begin
    unique case (quad_i)
      lptc_pkg::QUAD_0: begin
        rx = x_i;
        ry = y_i;
      end
      lptc_pkg::QUAD_90: begin
        rx = -y_i;
        ry = x_i;
      end
      lptc_pkg::QUAD_180: begin
        rx = -x_i;
        ry = -y_i;
      end
      lptc_pkg::QUAD_270: begin
        rx = y_i;
        ry = -x_i;
      end
      default: begin
        rx = x_i;
        ry = y_i;
      end
    endcase
  end

  assign offx = $signed({{(BW-32){cfg_i.offset_x[15]}}, cfg_i.offset_x, 16'd0});
  assign offy = $signed({{(BW-32){cfg_i.offset_y[15]}}, cfg_i.offset_y, 16'd0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_a_q <= '0;
    end else begin
      side_a_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bx_q <= $signed({rx[lptc_pkg::XW-1], rx}) + offx;
    by_q <= $signed({ry[lptc_pkg::XW-1], ry}) + offy;
  end

  // Stage B: partial products of the scale multiply
  lptc_pkg::side_t          side_b_q;
  logic [PLoW-1:0]          px_lo_q;
  logic [PLoW-1:0]          py_lo_q;
  logic signed [PHiW-1:0]   px_hi_q;
  logic signed [PHiW-1:0]   py_hi_q;
  logic signed [lptc_pkg::ScaleW:0] scale_s;

  assign scale_s = $signed({1'b0, cfg_i.cell_scale});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_b_q <= '0;
    end else begin
      side_b_q <= side_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px_lo_q <= bx_q[LoW-1:0] * cfg_i.cell_scale;
    py_lo_q <= by_q[LoW-1:0] * cfg_i.cell_scale;
    px_hi_q <= $signed(bx_q[BW-1:LoW]) * scale_s;
    py_hi_q <= $signed(by_q[BW-1:LoW]) * scale_s;
  end

  // Stage C: combine, drop 32 fraction bits, saturate
  logic signed [FullW-1:0] fx;
  logic signed [FullW-1:0] fy;
  logic                    done_q;
  logic                    kept_q;
  logic                    scan_end_q;
  logic signed [PtW-1:0]   point_x_q;
  logic signed [PtW-1:0]   point_y_q;

  assign fx = (FullW'(px_hi_q) <<< LoW) + $signed({{(FullW-PLoW){1'b0}}, px_lo_q});
  assign fy = (FullW'(py_hi_q) <<< LoW) + $signed({{(FullW-PLoW){1'b0}}, py_lo_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      kept_q <= 1'b0;
    end else begin
      done_q <= side_b_q.valid;
      kept_q <= side_b_q.valid & side_b_q.keep;
    end
  end

  // dropped samples report a zero point
  always_ff @(posedge clk_i) begin
    scan_end_q <= side_b_q.last;
    point_x_q  <= side_b_q.keep ? sat_pt(fx[FullW-1:32]) : '0;
    point_y_q  <= side_b_q.keep ? sat_pt(fy[FullW-1:32]) : '0;
  end

  assign done_o     = done_q;
  assign kept_o     = kept_q;
  assign scan_end_o = scan_end_q;
  assign point_x_o  = point_x_q;
  assign point_y_o  = point_y_q;

`ifndef SYNTH
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !kept_o) |-> (point_x_o == '0 && point_y_o == '0))
    else $error("dropped sample carries a nonzero point");
`endif

endmodule

// File: rtl/lidar_polar_to_cartesian_top.sv
`timescale 1ns / 1ps

// Converts one lidar range sample per clock into a map point. A sample is
// taken on every rising edge with start high; busy is always low, since the
// pipeline never stalls. Each sample gives exactly one result, flagged by a
// one-cycle done_o strobe. It passes in turn through the registers of the
// range gate and beam phase, of each CORDIC stage, of the quadrant fold and
// mounting offset, and of the split scale multiply and saturation.
// The result cannot be held off, so the receiver must take it in that cycle.
// A sample that fails the range gate or whose index is at or past the scan
// size comes out with kept_o low and a zero point. Registers are written
// through cfg_we_i/cfg_idx_i/cfg_wdata_i and should only change while no
// sample is in flight.
module lidar_polar_to_cartesian_top #(
  parameter int unsigned TRIG_STAGES = lptc_pkg::TRIG_STAGES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [lptc_pkg::IdxW-1:0]           sample_index_i,
  input  logic [lptc_pkg::RngW-1:0]           range_value_i,
  input  logic                                last_of_scan_i,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_idx_i,
  input  logic [lptc_pkg::CfgDataW-1:0]       cfg_wdata_i,
  output logic                                done_o,
  output logic signed [lptc_pkg::PtW-1:0]     point_x_o,
  output logic signed [lptc_pkg::PtW-1:0]     point_y_o,
  output logic                                kept_o,
  output logic                                scan_end_o
);

  lptc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_low   <= lptc_pkg::RANGE_LOW_RST;
      cfg_q.range_high  <= lptc_pkg::RANGE_HIGH_RST;
      cfg_q.angle_start <= '0;
      cfg_q.angle_step  <= '0;
      cfg_q.mount_yaw   <= '0;
      cfg_q.offset_x    <= '0;
      cfg_q.offset_y    <= '0;
      cfg_q.cell_scale  <= lptc_pkg::CELL_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (lptc_pkg::cfg_idx_e'(cfg_idx_i))
        lptc_pkg::CFG_RANGE_LOW:   cfg_q.range_low   <= cfg_wdata_i[15:0];
        lptc_pkg::CFG_RANGE_HIGH:  cfg_q.range_high  <= cfg_wdata_i[15:0];
        lptc_pkg::CFG_ANGLE_START: cfg_q.angle_start <= cfg_wdata_i;
        lptc_pkg::CFG_ANGLE_STEP:  cfg_q.angle_step  <= cfg_wdata_i;
        lptc_pkg::CFG_MOUNT_YAW:   cfg_q.mount_yaw   <= cfg_wdata_i;
        lptc_pkg::CFG_OFFSET_X:    cfg_q.offset_x    <= $signed(cfg_wdata_i[15:0]);
        lptc_pkg::CFG_OFFSET_Y:    cfg_q.offset_y    <= $signed(cfg_wdata_i[15:0]);
        lptc_pkg::CFG_CELL_SCALE:  cfg_q.cell_scale  <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  lptc_pkg::side_t                ph_side;
  lptc_pkg::quad_e                ph_quad;
  logic signed [lptc_pkg::XW-1:0] ph_x;
  logic signed [lptc_pkg::ZW-1:0] ph_z;
  lptc_pkg::side_t                cr_side;
  lptc_pkg::quad_e                cr_quad;
  logic signed [lptc_pkg::XW-1:0] cr_x;
  logic signed [lptc_pkg::XW-1:0] cr_y;

  lptc_phase u_phase (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (start & ~busy),
    .sample_index_i (sample_index_i),
    .range_value_i  (range_value_i),
    .last_of_scan_i (last_of_scan_i),
    .cfg_i          (cfg_q),
    .side_o         (ph_side),
    .quad_o         (ph_quad),
    .x_o            (ph_x),
    .z_o            (ph_z)
  );

  lptc_cordic #(
    .TRIG_STAGES (TRIG_STAGES)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (ph_side),
    .quad_i (ph_quad),
    .x_i    (ph_x),
    .z_i    (ph_z),
    .side_o (cr_side),
    .quad_o (cr_quad),
    .x_o    (cr_x),
    .y_o    (cr_y)
  );

  lptc_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .side_i     (cr_side),
    .quad_i     (cr_quad),
    .x_i        (cr_x),
    .y_i        (cr_y),
    .cfg_i      (cfg_q),
    .done_o     (done_o),
    .point_x_o  (point_x_o),
    .point_y_o  (point_y_o),
    .kept_o     (kept_o),
    .scan_end_o (scan_end_o)
  );

`ifndef SYNTH
  a_kept_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_o |-> done_o)
    else $error("kept flag raised without a result transaction");

  a_empty_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_q.range_low >= cfg_q.range_high && $stable(cfg_q) && $past($stable(cfg_q))
     && ph_side.valid) |-> !ph_side.keep)
    else $error("sample kept although the range window is empty");
`endif

endmodule
